// ----- sv/fpr_pkg.sv -----
// ----------------------------------------------------------------------------
// fpr_pkg - shared definitions for the fraction prime reducer
// Prime table, default parameters and the controller/datapath interface types.
// ----------------------------------------------------------------------------
package fpr_pkg;

    // port width of every payload field
    localparam int FIELD_W = 32;

    // parameter defaults
    localparam int PRIME_COUNT_DEF = 500;
    localparam int VALUE_WIDTH_DEF = 32;

    // table geometry
    localparam int TABLE_SIZE = 500;
    localparam int TBL_IW     = 9;   // index bits for the full table
    localparam int PRIME_W    = 12;  // largest prime 3571 fits 12 bits

    // first primes, ascending
    localparam logic [PRIME_W-1:0] PRIME_TABLE [0:TABLE_SIZE-1] = '{
        12'd2,12'd3,12'd5,12'd7,12'd11,12'd13,12'd17,12'd19,12'd23,12'd29,
        12'd31,12'd37,12'd41,12'd43,12'd47,12'd53,12'd59,12'd61,12'd67,12'd71,
        12'd73,12'd79,12'd83,12'd89,12'd97,12'd101,12'd103,12'd107,12'd109,12'd113,
        12'd127,12'd131,12'd137,12'd139,12'd149,12'd151,12'd157,12'd163,12'd167,12'd173,
        12'd179,12'd181,12'd191,12'd193,12'd197,12'd199,12'd211,12'd223,12'd227,12'd229,
        12'd233,12'd239,12'd241,12'd251,12'd257,12'd263,12'd269,12'd271,12'd277,12'd281,
        12'd283,12'd293,12'd307,12'd311,12'd313,12'd317,12'd331,12'd337,12'd347,12'd349,
        12'd353,12'd359,12'd367,12'd373,12'd379,12'd383,12'd389,12'd397,12'd401,12'd409,
        12'd419,12'd421,12'd431,12'd433,12'd439,12'd443,12'd449,12'd457,12'd461,12'd463,
        12'd467,12'd479,12'd487,12'd491,12'd499,12'd503,12'd509,12'd521,12'd523,12'd541,
        12'd547,12'd557,12'd563,12'd569,12'd571,12'd577,12'd587,12'd593,12'd599,12'd601,
        12'd607,12'd613,12'd617,12'd619,12'd631,12'd641,12'd643,12'd647,12'd653,12'd659,
        12'd661,12'd673,12'd677,12'd683,12'd691,12'd701,12'd709,12'd719,12'd727,12'd733,
        12'd739,12'd743,12'd751,12'd757,12'd761,12'd769,12'd773,12'd787,12'd797,12'd809,
        12'd811,12'd821,12'd823,12'd827,12'd829,12'd839,12'd853,12'd857,12'd859,12'd863,
        12'd877,12'd881,12'd883,12'd887,12'd907,12'd911,12'd919,12'd929,12'd937,12'd941,
        12'd947,12'd953,12'd967,12'd971,12'd977,12'd983,12'd991,12'd997,12'd1009,12'd1013,
        12'd1019,12'd1021,12'd1031,12'd1033,12'd1039,12'd1049,12'd1051,12'd1061,12'd1063,
        12'd1069,12'd1087,12'd1091,12'd1093,12'd1097,12'd1103,12'd1109,12'd1117,12'd1123,
        12'd1129,12'd1151,12'd1153,12'd1163,12'd1171,12'd1181,12'd1187,12'd1193,12'd1201,
        12'd1213,12'd1217,12'd1223,12'd1229,12'd1231,12'd1237,12'd1249,12'd1259,12'd1277,
        12'd1279,12'd1283,12'd1289,12'd1291,12'd1297,12'd1301,12'd1303,12'd1307,12'd1319,
        12'd1321,12'd1327,12'd1361,12'd1367,12'd1373,12'd1381,12'd1399,12'd1409,12'd1423,
        12'd1427,12'd1429,12'd1433,12'd1439,12'd1447,12'd1451,12'd1453,12'd1459,12'd1471,
        12'd1481,12'd1483,12'd1487,12'd1489,12'd1493,12'd1499,12'd1511,12'd1523,12'd1531,
        12'd1543,12'd1549,12'd1553,12'd1559,12'd1567,12'd1571,12'd1579,12'd1583,12'd1597,
        12'd1601,12'd1607,12'd1609,12'd1613,12'd1619,12'd1621,12'd1627,12'd1637,12'd1657,
        12'd1663,12'd1667,12'd1669,12'd1693,12'd1697,12'd1699,12'd1709,12'd1721,12'd1723,
        12'd1733,12'd1741,12'd1747,12'd1753,12'd1759,12'd1777,12'd1783,12'd1787,12'd1789,
        12'd1801,12'd1811,12'd1823,12'd1831,12'd1847,12'd1861,12'd1867,12'd1871,12'd1873,
        12'd1877,12'd1879,12'd1889,12'd1901,12'd1907,12'd1913,12'd1931,12'd1933,12'd1949,
        12'd1951,12'd1973,12'd1979,12'd1987,12'd1993,12'd1997,12'd1999,12'd2003,12'd2011,
        12'd2017,12'd2027,12'd2029,12'd2039,12'd2053,12'd2063,12'd2069,12'd2081,12'd2083,
        12'd2087,12'd2089,12'd2099,12'd2111,12'd2113,12'd2129,12'd2131,12'd2137,12'd2141,
        12'd2143,12'd2153,12'd2161,12'd2179,12'd2203,12'd2207,12'd2213,12'd2221,12'd2237,
        12'd2239,12'd2243,12'd2251,12'd2267,12'd2269,12'd2273,12'd2281,12'd2287,12'd2293,
        12'd2297,12'd2309,12'd2311,12'd2333,12'd2339,12'd2341,12'd2347,12'd2351,12'd2357,
        12'd2371,12'd2377,12'd2381,12'd2383,12'd2389,12'd2393,12'd2399,12'd2411,12'd2417,
        12'd2423,12'd2437,12'd2441,12'd2447,12'd2459,12'd2467,12'd2473,12'd2477,12'd2503,
        12'd2521,12'd2531,12'd2539,12'd2543,12'd2549,12'd2551,12'd2557,12'd2579,12'd2591,
        12'd2593,12'd2609,12'd2617,12'd2621,12'd2633,12'd2647,12'd2657,12'd2659,12'd2663,
        12'd2671,12'd2677,12'd2683,12'd2687,12'd2689,12'd2693,12'd2699,12'd2707,12'd2711,
        12'd2713,12'd2719,12'd2729,12'd2731,12'd2741,12'd2749,12'd2753,12'd2767,12'd2777,
        12'd2789,12'd2791,12'd2797,12'd2801,12'd2803,12'd2819,12'd2833,12'd2837,12'd2843,
        12'd2851,12'd2857,12'd2861,12'd2879,12'd2887,12'd2897,12'd2903,12'd2909,12'd2917,
        12'd2927,12'd2939,12'd2953,12'd2957,12'd2963,12'd2969,12'd2971,12'd2999,12'd3001,
        12'd3011,12'd3019,12'd3023,12'd3037,12'd3041,12'd3049,12'd3061,12'd3067,12'd3079,
        12'd3083,12'd3089,12'd3109,12'd3119,12'd3121,12'd3137,12'd3163,12'd3167,12'd3169,
        12'd3181,12'd3187,12'd3191,12'd3203,12'd3209,12'd3217,12'd3221,12'd3229,12'd3251,
        12'd3253,12'd3257,12'd3259,12'd3271,12'd3299,12'd3301,12'd3307,12'd3313,12'd3319,
        12'd3323,12'd3329,12'd3331,12'd3343,12'd3347,12'd3359,12'd3361,12'd3371,12'd3373,
        12'd3389,12'd3391,12'd3407,12'd3413,12'd3433,12'd3449,12'd3457,12'd3461,12'd3463,
        12'd3467,12'd3469,12'd3491,12'd3499,12'd3511,12'd3517,12'd3527,12'd3529,12'd3533,
        12'd3539,12'd3541,12'd3547,12'd3557,12'd3559,12'd3571
    };

    // table read; an index past the end gives zero
    function automatic logic [PRIME_W-1:0] prime_at(input logic [TBL_IW-1:0] idx);
        logic [PRIME_W-1:0] p;
        p = '0;
        if (int'(idx) < TABLE_SIZE) begin
            p = PRIME_TABLE[idx];
        end
        return p;
    endfunction

    // controller to datapath commands
    typedef struct packed {
        logic load;       // take a new input word, point at the top prime
        logic fetch;      // register the prime at the current index
        logic dec;        // move to the next smaller prime
        logic top;        // restart the scan at the largest prime
        logic div_start;  // load both dividers
        logic div_step;   // one quotient bit in both dividers
        logic take;       // replace the pair by the quotients
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic gt;         // both values strictly above the prime
        logic idx_zero;   // smallest prime reached
        logic div_last;   // final quotient bit this cycle
        logic rem_zero;   // both remainders are zero
    } t_stat;

endpackage

// ----- sv/fraction_prime_reducer_core.sv -----
// ----------------------------------------------------------------------------
// fraction_prime_reducer_core - reduces a signed fraction by common primes
// Scans the prime table from the top, divides by common factors, rescans.
//
//   channel  | ports                                      | handshake
//   ---------+--------------------------------------------+-------------------
//   input    | i_numerator_in, i_denominator_in           | start & !busy
//   result   | o_numerator_out, o_denominator_out         | o_valid, one cycle
//
// A skipped prime passes through fetch and test; a tested prime through fetch,
// test, one quotient bit a cycle and check. The scan makes one pass more than
// there are common divisions, each division restarting the scan at the top,
// and ends with the result strobe.
// The bit-serial dividers set the cost of each tested prime.
// Reset clears the controller only; busy is low straight after reset.
// The receiver cannot stall: the result strobe lasts exactly one cycle.
// ----------------------------------------------------------------------------
module fraction_prime_reducer_core #(
    parameter int PRIME_COUNT = fpr_pkg::PRIME_COUNT_DEF,
    parameter int VALUE_WIDTH = fpr_pkg::VALUE_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [fpr_pkg::FIELD_W-1:0] i_numerator_in,
    input  logic signed [fpr_pkg::FIELD_W-1:0] i_denominator_in,
    output logic                               o_valid,
    output logic signed [fpr_pkg::FIELD_W-1:0] o_numerator_out,
    output logic signed [fpr_pkg::FIELD_W-1:0] o_denominator_out
);

    fpr_pkg::t_cmd  cmd;
    fpr_pkg::t_stat stat;

    // controller
    fpr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_valid (o_valid)
    );

    // datapath
    fpr_datapath #(
        .PRIME_COUNT (PRIME_COUNT),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_cmd             (cmd),
        .i_numerator_in    (i_numerator_in),
        .i_denominator_in  (i_denominator_in),
        .o_stat            (stat),
        .o_numerator_out   (o_numerator_out),
        .o_denominator_out (o_denominator_out)
    );

endmodule

// ----- sv/fpr_datapath.sv -----
// ----------------------------------------------------------------------------
// fpr_datapath - value registers, prime index and two bit-serial dividers
// Holds the pair, walks the prime table and divides both values by a prime.
// ----------------------------------------------------------------------------
module fpr_datapath #(
    parameter int PRIME_COUNT = fpr_pkg::PRIME_COUNT_DEF,
    parameter int VALUE_WIDTH = fpr_pkg::VALUE_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  fpr_pkg::t_cmd                      i_cmd,
    input  logic signed [fpr_pkg::FIELD_W-1:0] i_numerator_in,
    input  logic signed [fpr_pkg::FIELD_W-1:0] i_denominator_in,
    output fpr_pkg::t_stat                     o_stat,
    output logic signed [fpr_pkg::FIELD_W-1:0] o_numerator_out,
    output logic signed [fpr_pkg::FIELD_W-1:0] o_denominator_out
);

    // parameters held to their legal ranges
    localparam int VW   = (VALUE_WIDTH < 8) ? 8 :
                          ((VALUE_WIDTH > fpr_pkg::FIELD_W) ? fpr_pkg::FIELD_W : VALUE_WIDTH);
    localparam int PC   = (PRIME_COUNT < 1) ? 1 :
                          ((PRIME_COUNT > fpr_pkg::TABLE_SIZE) ? fpr_pkg::TABLE_SIZE
                                                               : PRIME_COUNT);
    localparam int PW   = fpr_pkg::PRIME_W;
    localparam int IW   = (PC > 1) ? $clog2(PC) : 1;
    localparam int CNTW = $clog2(VW);
    localparam int CW   = (VW > PW + 1) ? VW : PW + 1;
    localparam logic [IW-1:0]   TOP_IDX  = IW'(PC - 1);
    localparam logic [CNTW-1:0] LAST_BIT = CNTW'(VW - 1);

    logic signed [VW-1:0] r_num, r_den;
    logic [IW-1:0]        r_idx;
    logic [PW-1:0]        r_prime;
    logic [VW-1:0]        r_wn, r_wd;      // dividend shifting out, quotient in
    logic [PW-1:0]        r_rn, r_rd;      // partial remainders
    logic [CNTW-1:0]      r_cnt;

    logic [PW:0]   sh_n, sh_d;
    logic          ge_n, ge_d;
    logic [PW-1:0] n_rn, n_rd;
    logic          num_gt, den_gt;

    // restoring division step for both values
    always_comb begin
        sh_n = {r_rn, r_wn[VW-1]};
        sh_d = {r_rd, r_wd[VW-1]};
        ge_n = (sh_n >= {1'b0, r_prime});
        ge_d = (sh_d >= {1'b0, r_prime});
        n_rn = ge_n ? PW'(sh_n - {1'b0, r_prime}) : sh_n[PW-1:0];
        n_rd = ge_d ? PW'(sh_d - {1'b0, r_prime}) : sh_d[PW-1:0];
    end

    // strictly-greater test, negative values never pass
    always_comb begin
        num_gt = !r_num[VW-1] && (CW'($unsigned(r_num)) > CW'(r_prime));
        den_gt = !r_den[VW-1] && (CW'($unsigned(r_den)) > CW'(r_prime));
    end

    // pair registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_num <= i_numerator_in[VW-1:0];
            r_den <= i_denominator_in[VW-1:0];
        end else if (i_cmd.take) begin
            r_num <= r_wn;
            r_den <= r_wd;
        end
    end

    // prime index and prime register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load || i_cmd.top) begin
            r_idx <= TOP_IDX;
        end else if (i_cmd.dec) begin
            r_idx <= r_idx - 1'b1;
        end
        if (i_cmd.fetch) begin
            r_prime <= fpr_pkg::prime_at(fpr_pkg::TBL_IW'(r_idx));
        end
    end

    // dividers
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_wn  <= r_num;
            r_wd  <= r_den;
            r_rn  <= '0;
            r_rd  <= '0;
            r_cnt <= LAST_BIT;
        end else if (i_cmd.div_step) begin
            r_wn  <= {r_wn[VW-2:0], ge_n};
            r_wd  <= {r_wd[VW-2:0], ge_d};
            r_rn  <= n_rn;
            r_rd  <= n_rd;
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // status
    always_comb begin
        o_stat.gt       = num_gt && den_gt;
        o_stat.idx_zero = (r_idx == '0);
        o_stat.div_last = (r_cnt == '0);
        o_stat.rem_zero = (r_rn == '0) && (r_rd == '0);
    end

    // results, sign-extended to the port width
    assign o_numerator_out   = fpr_pkg::FIELD_W'(r_num);
    assign o_denominator_out = fpr_pkg::FIELD_W'(r_den);

endmodule

// ----- sv/fpr_ctrl.sv -----
// ----------------------------------------------------------------------------
// fpr_ctrl - scan controller for the fraction prime reducer
// Sequences fetch, test and divide over the prime table and flags the result.
// ----------------------------------------------------------------------------
module fpr_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  fpr_pkg::t_stat i_stat,
    output fpr_pkg::t_cmd  o_cmd,
    output logic           o_busy,
    output logic           o_valid
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_FETCH = 6'b000010,
        S_TEST  = 6'b000100,
        S_DIV   = 6'b001000,
        S_CHECK = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_FETCH;
                end
            end
            S_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state     = S_TEST;
            end
            S_TEST: begin
                priority if (i_stat.gt) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else if (i_stat.idx_zero) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.dec = 1'b1;
                    n_state   = S_FETCH;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                // common factor found: divide and rescan from the top; else next prime or done
                priority if (i_stat.rem_zero) begin
                    o_cmd.take = 1'b1;
                    o_cmd.top  = 1'b1;
                    n_state    = S_FETCH;
                end else if (i_stat.idx_zero) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.dec = 1'b1;
                    n_state   = S_FETCH;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = (r_state == S_DONE);

endmodule
